[hw/rtl/bfr_pkg.sv]
`timescale 1ns / 1ps

package bfr_pkg;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 48;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE   = 2'd1;
    localparam logic [OP_W-1:0] OP_REWIND = 2'd2;
    localparam logic [OP_W-1:0] OP_MARK   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the input beat
        logic exec;   // perform the captured operation
    } bfr_cmd_t;

endpackage

[hw/rtl/bfr_ctrl.sv]
`timescale 1ns / 1ps

module bfr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output bfr_pkg::bfr_cmd_t cmd
);
    import bfr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign cmd.load = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.exec = (state_reg == ST_EXEC);

endmodule

[hw/rtl/bfr_datapath.sv]
`timescale 1ns / 1ps

module bfr_datapath
#(
    parameter int DEPTH = 4096,
    parameter int LW    = $clog2(DEPTH + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bfr_pkg::bfr_cmd_t            cmd,
    input  logic [bfr_pkg::OP_W-1:0]     op_in,
    input  logic [bfr_pkg::BYTE_W-1:0]   data_in,
    input  logic [bfr_pkg::POS_W-1:0]    saved_in,
    output logic [bfr_pkg::BYTE_W-1:0]   read_byte,
    output logic                         byte_valid,
    output logic                         accepted,
    output logic [LW-1:0]                fill_level,
    output logic [bfr_pkg::POS_W-1:0]    position,
    output logic                         end_of_stream
);
    import bfr_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] IDX_LAST   = IW'(DEPTH - 1);
    localparam logic [LW-1:0] LVL_DEPTH  = LW'(DEPTH);
    localparam logic [IW:0]   IDX_WRAP   = (IW + 1)'(DEPTH);

    // Captured beat.
    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [POS_W-1:0]  saved_reg;

    // Buffer state.
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    logic [IW-1:0]     wr_idx_reg, wr_idx_next;
    logic [LW-1:0]     level_reg, level_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              eos_reg, eos_next;
    logic              valid_reg, valid_next;
    logic              acc_reg, acc_next;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic              full;
    logic              empty;
    logic [POS_W-1:0]  rew_dist;
    logic [LW-1:0]     room;
    logic              rew_ok;
    logic [LW-1:0]     dist_lo;
    logic [IW-1:0]     back;
    logic [IW:0]       rd_back;
    logic              do_push;
    logic              do_take;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op_in;
            data_reg  <= data_in;
            saved_reg <= saved_in;
        end
    end

    assign full       = (level_reg == LVL_DEPTH);
    assign empty      = (level_reg == '0);
    assign rew_dist   = pos_reg - saved_reg;
    assign room       = LVL_DEPTH - level_reg;
    assign rew_ok     = (rew_dist != '0) && (rew_dist <= POS_W'(room));
    assign dist_lo    = rew_dist[LW-1:0];
    // A rewind by the whole depth leaves the read index in place.
    assign back       = (dist_lo == LVL_DEPTH) ? '0 : dist_lo[IW-1:0];
    assign rd_back    = (rd_idx_reg >= back)
                        ? ((IW + 1)'(rd_idx_reg) - (IW + 1)'(back))
                        : ((IW + 1)'(rd_idx_reg) + IDX_WRAP - (IW + 1)'(back));

    assign do_push = cmd.exec && (op_reg == OP_PUSH) && !full;
    assign do_take = cmd.exec && (op_reg == OP_TAKE) && !empty;

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        level_next  = level_reg;
        pos_next    = pos_reg;
        eos_next    = eos_reg;
        valid_next  = valid_reg;
        acc_next    = acc_reg;
        if (cmd.exec)
        begin
            valid_next = 1'b0;
            acc_next   = 1'b0;
            case (op_reg)
                OP_PUSH:
                begin
                    if (!full)
                    begin
                        wr_idx_next = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + 1'b1;
                        level_next  = level_reg + 1'b1;
                        acc_next    = 1'b1;
                    end
                end
                OP_TAKE:
                begin
                    if (!empty)
                    begin
                        rd_idx_next = (rd_idx_reg == IDX_LAST) ? '0 : rd_idx_reg + 1'b1;
                        level_next  = level_reg - 1'b1;
                        pos_next    = pos_reg + 1'b1;
                        valid_next  = 1'b1;
                    end
                end
                OP_REWIND:
                begin
                    if (rew_ok)
                    begin
                        rd_idx_next = rd_back[IW-1:0];
                        level_next  = level_reg + dist_lo;
                        pos_next    = saved_reg;
                        acc_next    = 1'b1;
                    end
                end
                OP_MARK:
                begin
                    eos_next = 1'b1;
                end
                default:
                begin
                    eos_next = eos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            level_reg  <= '0;
            pos_reg    <= '0;
            eos_reg    <= 1'b0;
            valid_reg  <= 1'b0;
            acc_reg    <= 1'b0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            level_reg  <= level_next;
            pos_reg    <= pos_next;
            eos_reg    <= eos_next;
            valid_reg  <= valid_next;
            acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_idx_reg] <= data_reg;
        end
        if (do_take)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    assign read_byte     = valid_reg ? rd_data_reg : '0;
    assign byte_valid    = valid_reg;
    assign accepted      = acc_reg;
    assign fill_level    = level_reg;
    assign position      = pos_reg;
    assign end_of_stream = eos_reg;

endmodule

[hw/rtl/byte_fifo_with_rewind_unit.sv]
`timescale 1ns / 1ps
// Each beat is captured, executed and presented in turn, set by the
// controller sequence and the registered store read; no new beat is
// taken until the result of the last one has been accepted.
// Reset: rst_n clears indices, fill level, position and the end flag at once;
// the byte store is not cleared and holds no meaning until written.
module byte_fifo_with_rewind_unit
#(
    parameter int DEPTH = 4096
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, lowest bit up: data_byte[7:0], saved_position[47:0].
    input  logic [55:0]                       s_tdata,
    // s_tuser: opcode[1:0].
    input  logic [bfr_pkg::OP_W-1:0]          s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, lowest bit up: read_byte[7:0], fill_level, position[47:0],
    // then zero padding to whole bytes.
    output logic [(((bfr_pkg::BYTE_W + $clog2(DEPTH + 1) + bfr_pkg::POS_W) + 7) / 8) * 8 - 1:0]
                                              m_tdata,
    // m_tuser, lowest bit up: byte_valid, accepted, end_of_stream.
    output logic [2:0]                        m_tuser
);
    import bfr_pkg::*;

    // Width of the fill level: enough to hold DEPTH itself.
    localparam int LW     = $clog2(DEPTH + 1);
    localparam int PAY_W  = BYTE_W + LW + POS_W;
    localparam int TD_W   = ((PAY_W + 7) / 8) * 8;

    bfr_cmd_t          cmd;
    logic [BYTE_W-1:0] read_byte;
    logic              byte_valid;
    logic              accepted;
    logic [LW-1:0]     fill_level;
    logic [POS_W-1:0]  position;
    logic              end_of_stream;

    // The controller walks each beat through capture, execute and present.
    // It raises s_tready only when no result is pending.
    bfr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the byte store, the read and write indices, the fill
    // level, the consumer position and the end flag.  The rewind check
    // computes the distance back to the saved position and compares it with
    // the free space in the execute cycle.
    bfr_datapath #(
        .DEPTH (DEPTH),
        .LW    (LW)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op_in         (s_tuser),
        .data_in       (s_tdata[BYTE_W-1:0]),
        .saved_in      (s_tdata[BYTE_W + POS_W - 1:BYTE_W]),
        .read_byte     (read_byte),
        .byte_valid    (byte_valid),
        .accepted      (accepted),
        .fill_level    (fill_level),
        .position      (position),
        .end_of_stream (end_of_stream)
    );

    // The result fields stay in registers until the next beat executes, so
    // the output holds steady while the consumer stalls.
    assign m_tdata = TD_W'({position, fill_level, read_byte});
    assign m_tuser = {end_of_stream, accepted, byte_valid};

endmodule

[hw/rtl/bfr_checker.sv]
`timescale 1ns / 1ps

module bfr_checker
#(
    parameter int DEPTH = 4096,
    parameter int TD_W  = 72
)
(
    input logic            clk,
    input logic            rst_n,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [TD_W-1:0] m_tdata,
    input logic [2:0]      m_tuser
);
    localparam int LW = $clog2(DEPTH + 1);

    // One operation at a time: no new beat is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
    else $error("input taken while a result is pending");

    // Every accepted beat yields its result once it has been executed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
    else $error("result missing after accepted beat");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

    // The fill level never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[8 + LW - 1:8] <= LW'(DEPTH)))
    else $error("fill level beyond depth");

    // A take never also reports an accepted push or rewind.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("byte valid and accepted both set");

endmodule

bind byte_fifo_with_rewind_unit bfr_checker #(
    .DEPTH (DEPTH),
    .TD_W  (TD_W)
) u_bfr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[test/tb_byte_fifo_with_rewind_unit.sv]
`timescale 1ns / 1ps

localparam int FIFO_DEPTH = 4096;
localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);
localparam int RES_W      = ((bfr_pkg::BYTE_W + LEVEL_W + bfr_pkg::POS_W + 7) / 8) * 8;

// One expected result beat, field by field.
typedef struct packed {
    logic [7:0]         read_byte;
    logic               byte_valid;
    logic               accepted;
    logic [LEVEL_W-1:0] fill_level;
    logic [47:0]        position;
    logic               end_of_stream;
} fifo_result_t;

// Keeps a private copy of the FIFO state, predicts the result of every
// accepted operation and compares the result beats against it in order.
class rewind_fifo_scoreboard;
    logic [7:0]   store [FIFO_DEPTH];
    int unsigned  rd_idx;
    int unsigned  wr_idx;
    int unsigned  level;
    int unsigned  pushes;      // distinct entries written, saturates at the depth
    logic [47:0]  position;
    logic         eos;
    fifo_result_t expected_beats [$];
    int unsigned  mismatches;

    function new();
        rd_idx     = 0;
        wr_idx     = 0;
        level      = 0;
        pushes     = 0;
        position   = '0;
        eos        = 1'b0;
        mismatches = 0;
    endfunction

    // A rewind that would succeed must not reach entries never written since
    // reset. Writes run from index zero upward, so before the store has been
    // filled once only the entries below the read index are safe to rewind over.
    function bit rewind_is_safe(logic [bfr_pkg::OP_W-1:0] op, logic [47:0] saved);
        logic [47:0] rew_dist;
        rew_dist = position - saved;
        if (op != bfr_pkg::OP_REWIND)
            return 1'b1;
        if (rew_dist == 0 || rew_dist > FIFO_DEPTH - level)
            return 1'b1;
        return pushes >= FIFO_DEPTH || rew_dist <= rd_idx;
    endfunction

    // Applies one operation to the private state and queues the result it causes.
    function void apply_fifo_op(logic [bfr_pkg::OP_W-1:0] op, logic [7:0] data,
                                logic [47:0] saved);
        fifo_result_t res;
        logic [47:0]  rew_dist;
        res = '0;
        case (op)
            bfr_pkg::OP_PUSH:
            begin
                if (level < FIFO_DEPTH)
                begin
                    store[wr_idx] = data;
                    wr_idx = (wr_idx + 1) % FIFO_DEPTH;
                    level++;
                    if (pushes < FIFO_DEPTH)
                        pushes++;
                    res.accepted = 1'b1;
                end
            end
            bfr_pkg::OP_TAKE:
            begin
                if (level > 0)
                begin
                    res.read_byte  = store[rd_idx];
                    res.byte_valid = 1'b1;
                    rd_idx = (rd_idx + 1) % FIFO_DEPTH;
                    level--;
                    position = position + 48'd1;
                end
            end
            bfr_pkg::OP_REWIND:
            begin
                rew_dist = position - saved;
                if (rew_dist != 0 && rew_dist <= FIFO_DEPTH - level)
                begin
                    // A rewind by the whole depth leaves the read index in place.
                    rd_idx   = (rd_idx + FIFO_DEPTH - int'(rew_dist % FIFO_DEPTH)) % FIFO_DEPTH;
                    level    = level + int'(rew_dist);
                    position = saved;
                    res.accepted = 1'b1;
                end
            end
            default:
            begin
                eos = 1'b1;
            end
        endcase
        res.fill_level    = level[LEVEL_W-1:0];
        res.position      = position;
        res.end_of_stream = eos;
        expected_beats.push_back(res);
    endfunction

    function void note_op(logic [bfr_pkg::OP_W-1:0] op, logic [55:0] tdata);
        apply_fifo_op(op, tdata[7:0], tdata[55:8]);
    endfunction

    function void compare_field(string name, logic [63:0] expected, logic [63:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     expected, actual);
            mismatches++;
        end
    endfunction

    function void check_beat(logic [RES_W-1:0] tdata, logic [2:0] tuser);
        fifo_result_t exp_res;
        if (expected_beats.size() == 0)
        begin
            $display("%0t: unexpected result beat, expected none, actual %0h/%0h",
                     $time, tdata, tuser);
            mismatches++;
            return;
        end
        exp_res = expected_beats.pop_front();
        compare_field("read_byte", exp_res.read_byte, tdata[7:0]);
        compare_field("fill_level", exp_res.fill_level, tdata[8 +: LEVEL_W]);
        compare_field("position", exp_res.position, tdata[8 + LEVEL_W +: 48]);
        compare_field("byte_valid", exp_res.byte_valid, tuser[0]);
        compare_field("accepted", exp_res.accepted, tuser[1]);
        compare_field("end_of_stream", exp_res.end_of_stream, tuser[2]);
    endfunction
endclass

module tb_byte_fifo_with_rewind_unit;

    // The slowest correct run is roughly 9400 operations, long receiver
    // hold-off included; the limit is many times what that run needs.
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_OPS   = 1150;
    localparam int IDLE_PERCENT = 28;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [55:0]              s_tdata;
    logic [bfr_pkg::OP_W-1:0] s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [RES_W-1:0]         m_tdata;
    logic [2:0]               m_tuser;

    rewind_fifo_scoreboard sb;
    int unsigned           cycle_count;
    int unsigned           results_seen;
    // Set by the sender for a stretch in which neither side idles.
    logic                  steady;

    byte_fifo_with_rewind_unit #(
        .DEPTH(FIFO_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: ends a run that hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Both handshakes are observed at the falling edge before the rising edge
    // that completes them. Inputs and ready signals only change at rising
    // edges, so the values seen here are the ones the edge will use, and the
    // scoreboard state is already up to date when the sender picks its next
    // operation at that rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_op(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                sb.check_beat(m_tdata, m_tuser);
                results_seen++;
            end
        end
    end

    // Receiver: random back-pressure, none during the steady stretch, and one
    // long hold-off early on so that the block backs up and stalls its input.
    initial
    begin
        bit held_off;
        held_off = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && results_seen >= 100)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    function automatic logic [47:0] noise48();
        return {$urandom(), $urandom()};
    endfunction

    // Offers one operation and waits for the rising edge that accepts it.
    // A rewind that would reach never-written storage is turned into one that
    // is refused for a zero distance.
    task automatic send_op(logic [bfr_pkg::OP_W-1:0] op, logic [7:0] data,
                           logic [47:0] saved);
        if (!sb.rewind_is_safe(op, saved))
            saved = sb.position;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {saved, data};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // Random gaps between beats, except during the steady stretch.
        if (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // One random operation. Rewind targets are mostly recent positions,
    // then the exact free-space boundary and one past it, then pure noise.
    task automatic send_random_op(int unsigned push_weight);
        int unsigned              pick;
        int unsigned              room;
        logic [bfr_pkg::OP_W-1:0] op;
        logic [47:0]              saved;
        pick = $urandom_range(99);
        if (pick < push_weight)
            op = bfr_pkg::OP_PUSH;
        else if (pick < 78)
            op = bfr_pkg::OP_TAKE;
        else if (pick < 98)
            op = bfr_pkg::OP_REWIND;
        else
            op = bfr_pkg::OP_MARK;
        room = FIFO_DEPTH - sb.level;
        pick = $urandom_range(99);
        if (op != bfr_pkg::OP_REWIND || pick >= 80)
            saved = noise48();
        else if (pick < 55)
            saved = sb.position - 48'($urandom_range(1, 64));
        else if (pick < 70)
            saved = sb.position - 48'(room);
        else
            saved = sb.position - 48'(room + 1);
        send_op(op, 8'($urandom()), saved);
    endtask

    initial
    begin
        sb = new();
        results_seen = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= bfr_pkg::OP_PUSH;
        steady   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: take and rewind on an empty FIFO, extreme bytes, rewinds
        // that succeed, that fail on a zero distance and on a wrapped distance,
        // take on empty, then end of stream marked twice.
        send_op(bfr_pkg::OP_TAKE, 8'hff, 48'hffff_ffff_ffff);
        send_op(bfr_pkg::OP_REWIND, 8'h00, 48'd0);
        send_op(bfr_pkg::OP_REWIND, 8'hff, 48'h8000_0000_0000);
        send_op(bfr_pkg::OP_PUSH, 8'h00, noise48());
        send_op(bfr_pkg::OP_PUSH, 8'hff, noise48());
        send_op(bfr_pkg::OP_PUSH, 8'ha5, noise48());
        send_op(bfr_pkg::OP_PUSH, 8'h5a, noise48());
        send_op(bfr_pkg::OP_TAKE, 8'($urandom()), noise48());
        send_op(bfr_pkg::OP_TAKE, 8'($urandom()), noise48());
        send_op(bfr_pkg::OP_REWIND, 8'($urandom()), 48'd0);
        send_op(bfr_pkg::OP_REWIND, 8'($urandom()), 48'd1);
        send_op(bfr_pkg::OP_TAKE, 8'($urandom()), noise48());
        send_op(bfr_pkg::OP_TAKE, 8'($urandom()), noise48());
        send_op(bfr_pkg::OP_TAKE, 8'($urandom()), noise48());
        send_op(bfr_pkg::OP_REWIND, 8'($urandom()), 48'd1);
        repeat (5) send_op(bfr_pkg::OP_TAKE, 8'($urandom()), noise48());
        send_op(bfr_pkg::OP_MARK, 8'($urandom()), noise48());
        send_op(bfr_pkg::OP_PUSH, 8'h3c, noise48());
        send_op(bfr_pkg::OP_MARK, 8'($urandom()), noise48());
        send_op(bfr_pkg::OP_TAKE, 8'($urandom()), noise48());

        // Fill past full so that pushes are refused, drain past empty, then
        // rewind by the whole depth from the empty FIFO and read it again.
        repeat (FIFO_DEPTH + 2) send_op(bfr_pkg::OP_PUSH, 8'($urandom()), noise48());
        repeat (FIFO_DEPTH + 1) send_op(bfr_pkg::OP_TAKE, 8'($urandom()), noise48());
        send_op(bfr_pkg::OP_REWIND, 8'($urandom()), sb.position - 48'(FIFO_DEPTH));
        send_op(bfr_pkg::OP_PUSH, 8'($urandom()), noise48());
        repeat (3) send_op(bfr_pkg::OP_TAKE, 8'($urandom()), noise48());

        // Random part in chunks that alternately favor pushes and takes, so
        // the fill level moves down and up in turn.
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i == 400)
                steady <= 1'b1;
            else if (i == 650)
                steady <= 1'b0;
            send_random_op(((i / 150) % 2 == 0) ? 25 : 55);
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every outstanding result, then keep watching to
        // catch any stray beat.
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
hw/rtl/bfr_pkg.sv
hw/rtl/bfr_ctrl.sv
hw/rtl/bfr_datapath.sv
hw/rtl/byte_fifo_with_rewind_unit.sv
hw/rtl/bfr_checker.sv
test/tb_byte_fifo_with_rewind_unit.sv
